### hdl/prwq_pkg.sv
// Shared types and codes for the process ready/wait queue engine.
// Holds the command and result transaction structs, the opcode, status and
// result codes, and the controller state type. Depends on nothing.
package prwq_pkg;

	localparam int ID_W     = 4;
	localparam int OPCODE_W = 3;
	localparam int STATUS_W = 3;
	localparam int RESULT_W = 3;

	typedef logic [ID_W-1:0]     proc_id_t;
	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [RESULT_W-1:0] result_t;

	// Opcodes
	localparam opcode_t OP_INSERT_READY = 3'd0;
	localparam opcode_t OP_INSERT_WAIT  = 3'd1;
	localparam opcode_t OP_WAKE_PARENT  = 3'd2;
	localparam opcode_t OP_SCHEDULE     = 3'd3;
	localparam opcode_t OP_SET_STATUS   = 3'd4;

	// Process status codes
	localparam status_t ST_FREE    = 3'd0;
	localparam status_t ST_READY   = 3'd1;
	localparam status_t ST_RUNNING = 3'd2;
	localparam status_t ST_BLOCKED = 3'd3;
	localparam status_t ST_ZOMBIE  = 3'd4;

	// Result codes
	localparam result_t RC_DONE      = 3'd0;
	localparam result_t RC_ALREADY   = 3'd1;
	localparam result_t RC_NOTFOUND  = 3'd2;
	localparam result_t RC_SCHEDULED = 3'd3;
	localparam result_t RC_SHUTDOWN  = 3'd4;
	localparam result_t RC_STUCK     = 3'd5;
	localparam result_t RC_REJECTED  = 3'd6;

	typedef struct packed {
		opcode_t  opcode;
		proc_id_t proc_id;
		status_t  new_status;
	} cmd_t;

	typedef struct packed {
		result_t  result_code;
		proc_id_t chosen_id;
	} rsp_t;

	// Access to the link memory, addressed by process id
	typedef struct packed {
		logic     we;
		proc_id_t waddr;
		proc_id_t wdata;
		proc_id_t raddr;
	} link_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_WHEAD,
		S_WALK,
		S_UNLINK,
		S_APPEND,
		S_DONE
	} state_t;

endpackage

### hdl/prwq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies. Read of an address written in the same cycle returns old data.
module prwq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/prwq_ctrl.sv
// Command sequencer for the ready/wait queue engine: list heads, tails,
// membership and activity flags, and the walk over the link memory.
// Depends on prwq_pkg; drives the link RAM through a link_req_t bundle.
module prwq_ctrl import prwq_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output rsp_t      res,
	output link_req_t mem_req,
	input  proc_id_t  mem_rdata
);

	localparam int AW = $clog2(NUM_PROCS);
	localparam int CW = $clog2(NUM_PROCS + 1);

	state_t         state_q, state_d;
	cmd_t           cmd_q;
	proc_id_t       ready_head_q, ready_tail_q, wait_head_q, wait_tail_q;
	proc_id_t       prev_q;
	logic [CW-1:0]  walk_cnt_q;
	logic [NUM_PROCS-1:0] in_ready_q, in_wait_q, active_q;
	result_t        rc_q;
	proc_id_t       chosen_q;

	logic [AW-1:0]  idx;
	logic [AW-1:0]  rh_idx;
	logic           id_ok;
	logic           rdy_empty;
	logic           wt_empty;
	logic           walk_last;
	logic           id_in_ready;
	logic           id_in_wait;

	assign idx         = AW'(cmd_q.proc_id);
	assign rh_idx      = AW'(ready_head_q);
	assign id_ok       = (32'(cmd_q.proc_id) < NUM_PROCS);
	assign rdy_empty   = ~|in_ready_q;
	assign wt_empty    = ~|in_wait_q;
	assign walk_last   = (walk_cnt_q == CW'(NUM_PROCS - 1));
	assign id_in_ready = id_ok && in_ready_q[idx];
	assign id_in_wait  = id_ok && in_wait_q[idx];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q.opcode)
					OP_SCHEDULE: begin
						state_d = rdy_empty ? S_DONE : S_POP;
					end
					OP_WAKE_PARENT: begin
						if (!id_in_wait) begin
							state_d = S_DONE;
						end else if (wait_head_q == cmd_q.proc_id) begin
							state_d = (wait_tail_q != cmd_q.proc_id) ? S_WHEAD : S_APPEND;
						end else begin
							state_d = S_WALK;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_POP:    state_d = S_DONE;
			S_WHEAD:  state_d = S_APPEND;
			S_WALK: begin
				if (mem_rdata == cmd_q.proc_id) begin
					state_d = S_UNLINK;
				end else if (walk_last) begin
					state_d = S_APPEND;
				end
			end
			S_UNLINK: state_d = S_APPEND;
			S_APPEND: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs: handshakes and link memory accesses
	always_comb begin
		cmd_ready         = (state_q == S_IDLE);
		res_valid         = (state_q == S_DONE);
		res.result_code   = rc_q;
		res.chosen_id     = chosen_q;
		mem_req           = '0;
		case (state_q)
			S_EXEC: begin
				case (cmd_q.opcode)
					OP_SCHEDULE: begin
						mem_req.raddr = ready_head_q;
					end
					OP_WAKE_PARENT: begin
						mem_req.raddr = (wait_head_q == cmd_q.proc_id) ?
							cmd_q.proc_id : wait_head_q;
					end
					OP_INSERT_READY: begin
						if (id_ok && !id_in_ready && !id_in_wait && !rdy_empty) begin
							mem_req.we    = 1'b1;
							mem_req.waddr = ready_tail_q;
							mem_req.wdata = cmd_q.proc_id;
						end
					end
					OP_INSERT_WAIT: begin
						if (id_ok && !id_in_ready && !id_in_wait && !wt_empty) begin
							mem_req.we    = 1'b1;
							mem_req.waddr = wait_tail_q;
							mem_req.wdata = cmd_q.proc_id;
						end
					end
					default: begin
						mem_req.raddr = '0;
					end
				endcase
			end
			S_WALK: begin
				mem_req.raddr = (mem_rdata == cmd_q.proc_id) ? cmd_q.proc_id : mem_rdata;
			end
			S_UNLINK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = prev_q;
				mem_req.wdata = mem_rdata;
			end
			S_APPEND: begin
				if (!rdy_empty) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ready_tail_q;
					mem_req.wdata = cmd_q.proc_id;
				end
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// State register and list bookkeeping. The done state parts each command's
	// last write from the next command's first read, so no forwarding is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			ready_head_q <= '0;
			ready_tail_q <= '0;
			wait_head_q  <= '0;
			wait_tail_q  <= '0;
			prev_q       <= '0;
			walk_cnt_q   <= '0;
			in_ready_q   <= '0;
			in_wait_q    <= '0;
			active_q     <= '0;
			rc_q         <= RC_NOTFOUND;
			chosen_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						rc_q     <= RC_NOTFOUND;
						chosen_q <= '0;
					end
				end
				S_EXEC: begin
					case (cmd_q.opcode)
						OP_INSERT_READY: begin
							if (id_in_ready) begin
								rc_q <= RC_ALREADY;
							end else if (id_in_wait) begin
								rc_q <= RC_REJECTED;
							end else if (id_ok) begin
								if (rdy_empty) begin
									ready_head_q <= cmd_q.proc_id;
								end
								ready_tail_q    <= cmd_q.proc_id;
								in_ready_q[idx] <= 1'b1;
								active_q[idx]   <= 1'b1;
								rc_q            <= RC_DONE;
							end
						end
						OP_INSERT_WAIT: begin
							if (id_in_wait) begin
								rc_q <= RC_ALREADY;
							end else if (id_in_ready) begin
								rc_q <= RC_REJECTED;
							end else if (id_ok) begin
								if (wt_empty) begin
									wait_head_q <= cmd_q.proc_id;
								end
								wait_tail_q    <= cmd_q.proc_id;
								in_wait_q[idx] <= 1'b1;
								active_q[idx]  <= 1'b1;
								rc_q           <= RC_DONE;
							end
						end
						OP_SCHEDULE: begin
							if (rdy_empty) begin
								rc_q <= (|active_q) ? RC_STUCK : RC_SHUTDOWN;
							end
						end
						OP_WAKE_PARENT: begin
							prev_q     <= wait_head_q;
							walk_cnt_q <= '0;
						end
						OP_SET_STATUS: begin
							if (id_ok) begin
								active_q[idx] <= !((cmd_q.new_status == ST_FREE) ||
									(cmd_q.new_status == ST_ZOMBIE));
								rc_q          <= RC_DONE;
							end
						end
						default: begin
							rc_q <= RC_NOTFOUND;
						end
					endcase
				end
				// Pop the ready head and mark it running
				S_POP: begin
					if (ready_tail_q != ready_head_q) begin
						ready_head_q <= mem_rdata;
					end
					in_ready_q[rh_idx] <= 1'b0;
					active_q[rh_idx]   <= 1'b1;
					chosen_q           <= ready_head_q;
					rc_q               <= RC_SCHEDULED;
				end
				S_WHEAD: begin
					wait_head_q <= mem_rdata;
				end
				// Advance the walk until the predecessor of the woken id is found
				S_WALK: begin
					if (mem_rdata != cmd_q.proc_id) begin
						prev_q     <= mem_rdata;
						walk_cnt_q <= walk_cnt_q + CW'(1);
					end
				end
				S_UNLINK: begin
					if (wait_tail_q == cmd_q.proc_id) begin
						wait_tail_q <= prev_q;
					end
				end
				// Drop from the wait list and append to the ready list
				S_APPEND: begin
					in_wait_q[idx] <= 1'b0;
					if (rdy_empty) begin
						ready_head_q <= cmd_q.proc_id;
					end
					ready_tail_q    <= cmd_q.proc_id;
					in_ready_q[idx] <= 1'b1;
					active_q[idx]   <= 1'b1;
					rc_q            <= RC_DONE;
				end
				default: begin
					walk_cnt_q <= walk_cnt_q;
				end
			endcase
		end
	end

	// A process sits on at most one list
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready_q & in_wait_q) == '0)
		else $error("process on both lists");

	// The walk never runs past the number of processes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (walk_cnt_q < CW'(NUM_PROCS)))
		else $error("wait list walk overran");

	// Link writes happen only where a list is spliced
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == S_EXEC || state_q == S_UNLINK || state_q == S_APPEND))
		else $error("unexpected link write");

	// A handed-over result returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle");

	// A successful schedule leaves the chosen process off the ready list
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> !in_ready_q[$past(rh_idx)])
		else $error("scheduled process still on ready list");

endmodule

### hdl/process_ready_wait_queue_top.sv
// Process ready/wait queue engine: FIFO ready list and wait list over one link RAM.
// A command goes from idle through execute to done, then to the output register;
// schedule adds a pop; wake may update the head or walk the wait list, then appends.
// One command at a time: the next is accepted only once the last result has passed
// to the output register, later while that register holds an unaccepted result.
// Reset empties both lists and frees all processes; the link RAM is not cleared.
module process_ready_wait_queue_top import prwq_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(NUM_PROCS);

	link_req_t mem_req;
	proc_id_t  mem_rdata;
	logic      res_valid;
	logic      res_ready;
	rsp_t      res;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	prwq_ctrl #(
		.NUM_PROCS (NUM_PROCS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	prwq_ram #(
		.WIDTH (ID_W),
		.DEPTH (NUM_PROCS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (AW'(mem_req.waddr)),
		.wdata (mem_req.wdata),
		.raddr (AW'(mem_req.raddr)),
		.rdata (mem_rdata)
	);

	// Output register: hold the result until the transaction completes
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
